>>> rtl/bpfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfl_pkg
// Shared types, codes and sizing helpers of the block pool free list unit.
// ----------------------------------------------------------------------------
package bpfl_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int CNT_W          = 7;
    localparam int BIDX_W         = 6;
    localparam int STAT_W         = 3;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int RESET_COUNT    = 64;

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_DISABLED = 3'd1;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_CORRUPT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_DOUBLE   = 3'd4;
    localparam logic [STAT_W-1:0] ST_IGNORED  = 3'd5;

    // Register word index on the configuration port
    localparam logic REG_BLOCK_COUNT = 1'b0;

    typedef struct packed {
        logic              req_type;
        logic [BIDX_W-1:0] block_index;
    } bpfl_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BIDX_W-1:0] granted_index;
        logic [CNT_W-1:0]  free_blocks;
    } bpfl_rsp_t;

    typedef struct packed {
        logic             init;
        logic [CNT_W-1:0] init_count;
        logic [CNT_W-1:0] count;
    } bpfl_cfg_t;

    // Blocks actually usable: a 7-bit count never exceeds 127
    function automatic int pool_cap(input int max_blocks);
        int cap;
        cap = max_blocks;
        if (cap > 127) begin
            cap = 127;
        end
        return cap;
    endfunction

    function automatic int cap_width(input int cap);
        int w;
        w = (cap > 1) ? $clog2(cap) : 1;
        return w;
    endfunction

    function automatic int reset_count(input int cap);
        int c;
        c = (cap < RESET_COUNT) ? cap : RESET_COUNT;
        return c;
    endfunction

endpackage

>>> rtl/block_pool_free_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_pool_free_list_unit
// LIFO free-list block allocator with per-block in-use flags.
// ----------------------------------------------------------------------------
// One request is handled at a time. A release of an in-range index reads
// the flag, updates it and loads the result register; an acquire first
// reads the stack top, which must be known before the flag of the popped
// block can be read. Requests answered at once (pool disabled, list empty,
// index out of range) go straight to the result load. The two dependent
// reads of the registered-read stack and flag memories set this order. A
// new request is taken while a result still waits on the m_ side. Writing
// block_count rebuilds the pool in the same cycle: no clearing pass is
// needed, since never-written stack entries are recognised by a
// low-watermark of the stack depth and flags by per-block valid bits.
// ----------------------------------------------------------------------------
module block_pool_free_list_unit #(
    parameter int MAX_BLOCKS = bpfl_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bpfl_pkg::bpfl_req_t           s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bpfl_pkg::bpfl_rsp_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpfl_pkg::PADDR_W-1:0]  paddr,
    input  logic [bpfl_pkg::PDATA_W-1:0]  pwdata,
    output logic [bpfl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int POOL_CAP = bpfl_pkg::pool_cap(MAX_BLOCKS);
    localparam int IDX_W    = bpfl_pkg::cap_width(POOL_CAP);
    localparam int CNT_W    = bpfl_pkg::CNT_W;
    localparam logic [CNT_W-1:0] RST_CNT =
        CNT_W'(bpfl_pkg::reset_count(POOL_CAP));

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_STACK = 2'd1;
    localparam logic [1:0] S_FLAG  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    bpfl_pkg::bpfl_cfg_t cfg;

    logic [1:0]          state_reg, state_next;
    bpfl_pkg::bpfl_req_t req_reg, req_next;
    logic [IDX_W-1:0]    top_reg, top_next;
    logic [CNT_W-1:0]    depth_reg, depth_next;
    logic [CNT_W-1:0]    low_reg, low_next;
    logic [POOL_CAP-1:0] valid_reg, valid_next;
    bpfl_pkg::bpfl_rsp_t rsp_reg, rsp_next;
    logic                m_valid_reg, m_valid_next;
    bpfl_pkg::bpfl_rsp_t m_data_reg, m_data_next;

    logic             accept;
    logic [CNT_W-1:0] pos;
    logic [IDX_W-1:0] stack_rdata;
    logic [IDX_W-1:0] top_val;
    logic             stack_we;
    logic [IDX_W-1:0] flag_raddr;
    logic [0:0]       flag_rdata;
    logic             flag_we;
    logic [0:0]       flag_wdata;
    logic             in_use;
    logic             out_free;

    bpfl_cfg #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Free stack: entry p holds the index stored at depth p
    bpfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_CAP)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stack_we),
        .waddr (IDX_W'(depth_reg)),
        .wdata (top_reg),
        .raddr (IDX_W'(pos)),
        .rdata (stack_rdata)
    );

    bpfl_ram #(
        .WIDTH (1),
        .DEPTH (POOL_CAP)
    ) u_flag_ram (
        .aclk  (aclk),
        .we    (flag_we),
        .waddr (top_reg),
        .wdata (flag_wdata),
        .raddr (flag_raddr),
        .rdata (flag_rdata)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign pos      = depth_reg - CNT_W'(1);
    assign out_free = !m_valid_reg || m_ready;

    // Entries below the low-watermark were never pushed and still hold their
    // initial value, which equals the position itself
    assign top_val = (pos >= low_reg) ? stack_rdata : IDX_W'(pos);
    assign in_use  = flag_rdata[0] && valid_reg[top_reg];

    always_comb begin
        flag_raddr = top_val;
        if (state_reg == S_IDLE) begin
            flag_raddr = IDX_W'(s_data.block_index);
        end
    end

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        top_next     = top_reg;
        depth_next   = depth_reg;
        low_next     = low_reg;
        valid_next   = valid_reg;
        rsp_next     = rsp_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        stack_we     = 1'b0;
        flag_we      = 1'b0;
        flag_wdata   = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_next               = s_data;
                    top_next               = IDX_W'(s_data.block_index);
                    rsp_next.status        = bpfl_pkg::ST_OK;
                    rsp_next.granted_index = '0;
                    rsp_next.free_blocks   = depth_reg;
                    priority if (cfg.count == '0) begin
                        rsp_next.status = bpfl_pkg::ST_DISABLED;
                        state_next      = S_OUT;
                    end else if (s_data.req_type == bpfl_pkg::REQ_ACQUIRE) begin
                        if (depth_reg == '0) begin
                            rsp_next.status = bpfl_pkg::ST_EXHAUSTED;
                            state_next      = S_OUT;
                        end else begin
                            state_next = S_STACK;
                        end
                    end else if ({1'b0, s_data.block_index} >= cfg.count) begin
                        rsp_next.status = bpfl_pkg::ST_IGNORED;
                        state_next      = S_OUT;
                    end else begin
                        state_next = S_FLAG;
                    end
                end
            end
            S_STACK: begin
                // Pop: the entry is gone whatever its flag says
                top_next   = top_val;
                depth_next = pos;
                if (pos < low_reg) begin
                    low_next = pos;
                end
                state_next = S_FLAG;
            end
            S_FLAG: begin
                rsp_next.free_blocks = depth_reg;
                if (req_reg.req_type == bpfl_pkg::REQ_ACQUIRE) begin
                    if (in_use) begin
                        rsp_next.status = bpfl_pkg::ST_CORRUPT;
                    end else begin
                        flag_we                = 1'b1;
                        flag_wdata             = 1'b1;
                        valid_next[top_reg]    = 1'b1;
                        rsp_next.granted_index = bpfl_pkg::BIDX_W'(top_reg);
                    end
                end else begin
                    if (!in_use) begin
                        rsp_next.status = bpfl_pkg::ST_DOUBLE;
                    end else begin
                        flag_we              = 1'b1;
                        valid_next[top_reg]  = 1'b1;
                        stack_we             = 1'b1;
                        depth_next           = depth_reg + CNT_W'(1);
                        rsp_next.free_blocks = depth_reg + CNT_W'(1);
                    end
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    m_data_next  = rsp_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Rebuild the pool on a block_count write
        if (cfg.init) begin
            depth_next = cfg.init_count;
            low_next   = cfg.init_count;
            valid_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            depth_reg   <= RST_CNT;
            low_reg     <= RST_CNT;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            low_reg     <= low_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        top_reg    <= top_next;
        rsp_reg    <= rsp_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Free list can never hold more entries than the pool has blocks
    a_depth_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= cfg.count)
        else $error("free list deeper than block count");

    a_low_le_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        low_reg <= depth_reg)
        else $error("stack low-watermark above depth");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside result stage");

    a_grant_marks_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLAG && req_reg.req_type == bpfl_pkg::REQ_ACQUIRE &&
         !in_use && !cfg.init) |=> valid_reg[$past(top_reg)])
        else $error("granted block not marked in use");

endmodule

>>> rtl/bpfl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bpfl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfl_cfg
// APB register file: holds block_count and flags a pool re-initialisation.
// ----------------------------------------------------------------------------
module bpfl_cfg #(
    parameter int MAX_BLOCKS = bpfl_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpfl_pkg::PADDR_W-1:0]  paddr,
    input  logic [bpfl_pkg::PDATA_W-1:0]  pwdata,
    output logic [bpfl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output bpfl_pkg::bpfl_cfg_t           cfg
);

    localparam int POOL_CAP = bpfl_pkg::pool_cap(MAX_BLOCKS);
    localparam logic [bpfl_pkg::CNT_W-1:0] CAP_CNT =
        bpfl_pkg::CNT_W'(POOL_CAP);
    localparam logic [bpfl_pkg::CNT_W-1:0] RST_CNT =
        bpfl_pkg::CNT_W'(bpfl_pkg::reset_count(POOL_CAP));

    logic [bpfl_pkg::CNT_W-1:0] count_reg;
    logic [bpfl_pkg::CNT_W-1:0] count_next;
    logic [bpfl_pkg::CNT_W-1:0] wr_count;
    logic                       wr_hit;

    assign pready = 1'b1;

    // Saturate to the pool capacity
    assign wr_count = (pwdata[bpfl_pkg::CNT_W-1:0] > CAP_CNT) ?
                      CAP_CNT : pwdata[bpfl_pkg::CNT_W-1:0];
    assign wr_hit   = psel && penable && pwrite &&
                      (paddr[2] == bpfl_pkg::REG_BLOCK_COUNT);

    always_comb begin
        count_next = count_reg;
        if (wr_hit) begin
            count_next = wr_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= RST_CNT;
        end else begin
            count_reg <= count_next;
        end
    end

    assign prdata = (paddr[2] == bpfl_pkg::REG_BLOCK_COUNT) ?
                    bpfl_pkg::PDATA_W'(count_reg) : '0;

    assign cfg.init       = wr_hit;
    assign cfg.init_count = wr_count;
    assign cfg.count      = count_reg;

endmodule

>>> verif/tb_block_pool_free_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_pool_free_list_unit
// Self-checking testbench for the LIFO free-list block allocator.
// ----------------------------------------------------------------------------
// Requests go to the block through a queued valid/ready driver. Each accepted
// request is run through an in-bench model of the free list, stack depth and
// in-use flags, and every returned transaction is checked field by field
// against the oldest prediction. The pool size is rewritten over the APB
// port between phases, covering a disabled pool, one block, small pools,
// the full pool and counts above the maximum. Both channels stall at random,
// and one long stall on the result side backs the block up.
// ----------------------------------------------------------------------------
module tb_block_pool_free_list_unit;

    localparam int CLK_HALF       = 6;
    localparam int POOL_MAX       = bpfl_pkg::MAX_BLOCKS_DEF;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int NUM_PHASES     = 9;

    // Pool size, item count and acquire share of each random phase
    localparam int PHASE_COUNT [NUM_PHASES] = '{64, 1, 2, 127, 5, 0, 33, 100, 64};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{200, 50, 50, 110, 80, 20, 120, 110, 110};
    localparam int PHASE_ACQ   [NUM_PHASES] = '{85, 50, 55, 60, 55, 50, 70, 45, 55};

    logic                         aclk    = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    bpfl_pkg::bpfl_req_t          s_data  = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    bpfl_pkg::bpfl_rsp_t          m_data;
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [bpfl_pkg::PADDR_W-1:0] paddr   = '0;
    logic [bpfl_pkg::PDATA_W-1:0] pwdata  = '0;
    logic [bpfl_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    // Pool model
    logic [bpfl_pkg::CNT_W-1:0]  pool_count;
    logic [bpfl_pkg::CNT_W-1:0]  lifo_depth;
    logic [bpfl_pkg::BIDX_W-1:0] lifo_entry [POOL_MAX];
    logic [POOL_MAX-1:0]         block_busy;

    bpfl_pkg::bpfl_req_t req_backlog [$];
    bpfl_pkg::bpfl_rsp_t rsp_due [$];
    bpfl_pkg::bpfl_rsp_t rsp_want;

    logic calm    = 1'b0;
    logic hold_go = 1'b0;
    int   hold_left = 0;
    int   s_gap = 0;
    int   m_gap = 0;

    int errors        = 0;
    int reqs_accepted = 0;
    int rsps_checked  = 0;
    int cfg_writes    = 0;
    int status_seen [8];

    block_pool_free_list_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    task automatic log_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        errors++;
    endtask

    function automatic void pool_rebuild(input int requested);
        int n;
        n = requested & 'h7F;
        if (n > POOL_MAX) begin
            n = POOL_MAX;
        end
        pool_count = bpfl_pkg::CNT_W'(n);
        lifo_depth = bpfl_pkg::CNT_W'(n);
        block_busy = '0;
        for (int i = 0; i < POOL_MAX; i++) begin
            lifo_entry[i] = (i < n) ? bpfl_pkg::BIDX_W'(i) : '0;
        end
    endfunction

    function automatic bpfl_pkg::bpfl_rsp_t pool_predict(input bpfl_pkg::bpfl_req_t req);
        bpfl_pkg::bpfl_rsp_t rsp;
        logic [bpfl_pkg::BIDX_W-1:0] top;
        rsp = '0;
        rsp.status = bpfl_pkg::ST_OK;
        if (pool_count == 0) begin
            rsp.status = bpfl_pkg::ST_DISABLED;
        end else if (req.req_type == bpfl_pkg::REQ_ACQUIRE) begin
            if (lifo_depth == 0) begin
                rsp.status = bpfl_pkg::ST_EXHAUSTED;
            end else begin
                lifo_depth = lifo_depth - 1'b1;
                top = lifo_entry[lifo_depth];
                // a popped block already in use is lost from the list
                if (block_busy[top]) begin
                    rsp.status = bpfl_pkg::ST_CORRUPT;
                end else begin
                    block_busy[top] = 1'b1;
                    rsp.granted_index = top;
                end
            end
        end else begin
            if ({1'b0, req.block_index} >= pool_count) begin
                rsp.status = bpfl_pkg::ST_IGNORED;
            end else if (!block_busy[req.block_index]) begin
                rsp.status = bpfl_pkg::ST_DOUBLE;
            end else begin
                block_busy[req.block_index] = 1'b0;
                if (lifo_depth < POOL_MAX) begin
                    lifo_entry[lifo_depth] = req.block_index;
                    lifo_depth = lifo_depth + 1'b1;
                end
            end
        end
        rsp.free_blocks = lifo_depth;
        return rsp;
    endfunction

    // Choose a block currently held, so that releases mostly succeed
    function automatic logic [bpfl_pkg::BIDX_W-1:0] pick_held_block(
        input logic [bpfl_pkg::BIDX_W-1:0] fallback);
        int n;
        int k;
        n = 0;
        for (int i = 0; i < POOL_MAX; i++) begin
            if (block_busy[i]) begin
                n++;
            end
        end
        if (n == 0) begin
            return fallback;
        end
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < POOL_MAX; i++) begin
            if (block_busy[i]) begin
                if (k == 0) begin
                    return bpfl_pkg::BIDX_W'(i);
                end
                k--;
            end
        end
        return fallback;
    endfunction

    function automatic bpfl_pkg::bpfl_req_t random_req(input int acq_pct);
        bpfl_pkg::bpfl_req_t req;
        req.block_index = bpfl_pkg::BIDX_W'($urandom_range(0, POOL_MAX - 1));
        if ($urandom_range(0, 99) < 12) begin
            // noise: any operation on any index
            req.req_type = 1'($urandom_range(0, 1));
        end else if ($urandom_range(0, 99) < acq_pct) begin
            req.req_type = bpfl_pkg::REQ_ACQUIRE;
        end else begin
            req.req_type = bpfl_pkg::REQ_RELEASE;
            req.block_index = pick_held_block(req.block_index);
        end
        return req;
    endfunction

    task automatic queue_req(input logic kind, input logic [bpfl_pkg::BIDX_W-1:0] idx);
        bpfl_pkg::bpfl_req_t req;
        req.req_type = kind;
        req.block_index = idx;
        req_backlog.push_back(req);
    endtask

    // Sample on the falling edge, once the driver's updates have settled
    task automatic wait_idle();
        @(negedge aclk);
        while (req_backlog.size() != 0 || s_valid || rsp_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_block_count(input int value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {bpfl_pkg::REG_BLOCK_COUNT, 2'b00};
        pwdata  <= bpfl_pkg::PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pool_rebuild(value);
        cfg_writes++;
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap   <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_gap != 0) begin
                s_gap   <= s_gap - 1;
                s_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
                s_data  <= req_backlog.pop_front();
                s_valid <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) begin
                    s_gap <= $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Long hold-off of the result channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // Result-side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_gap   <= 0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
        end else if (m_gap != 0) begin
            m_gap   <= m_gap - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            m_gap   <= $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Prediction on acceptance, comparison on return
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                rsp_due.push_back(pool_predict(s_data));
                reqs_accepted++;
            end
            if (m_valid && m_ready) begin
                status_seen[m_data.status]++;
                if (rsp_due.size() == 0) begin
                    log_mismatch($sformatf("result with nothing pending: status %0d",
                                           m_data.status));
                end else begin
                    rsp_want = rsp_due.pop_front();
                    rsps_checked++;
                    if (m_data.status !== rsp_want.status) begin
                        log_mismatch($sformatf("status got %0d want %0d",
                                               m_data.status, rsp_want.status));
                    end
                    if (m_data.granted_index !== rsp_want.granted_index) begin
                        log_mismatch($sformatf("granted_index got %0d want %0d",
                                               m_data.granted_index, rsp_want.granted_index));
                    end
                    if (m_data.free_blocks !== rsp_want.free_blocks) begin
                        log_mismatch($sformatf("free_blocks got %0d want %0d",
                                               m_data.free_blocks, rsp_want.free_blocks));
                    end
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("Testbench timed out");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int drain;
        pool_rebuild(bpfl_pkg::RESET_COUNT);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Full pool straight out of reset
        queue_req(bpfl_pkg::REQ_ACQUIRE, 6'd0);
        queue_req(bpfl_pkg::REQ_ACQUIRE, 6'd0);
        queue_req(bpfl_pkg::REQ_RELEASE, 6'd63);
        queue_req(bpfl_pkg::REQ_RELEASE, 6'd63);
        queue_req(bpfl_pkg::REQ_RELEASE, 6'd0);
        queue_req(bpfl_pkg::REQ_ACQUIRE, 6'h3F);

        // Disabled pool
        write_block_count(0);
        queue_req(bpfl_pkg::REQ_ACQUIRE, 6'd0);
        queue_req(bpfl_pkg::REQ_RELEASE, 6'h3F);

        // Single block: exhaust, out-of-range and double release
        write_block_count(1);
        queue_req(bpfl_pkg::REQ_ACQUIRE, 6'd0);
        queue_req(bpfl_pkg::REQ_ACQUIRE, 6'h2A);
        queue_req(bpfl_pkg::REQ_RELEASE, 6'd63);
        queue_req(bpfl_pkg::REQ_RELEASE, 6'd1);
        queue_req(bpfl_pkg::REQ_RELEASE, 6'd0);
        queue_req(bpfl_pkg::REQ_RELEASE, 6'd0);

        // Count above the maximum saturates
        write_block_count(127);
        queue_req(bpfl_pkg::REQ_RELEASE, 6'd63);
        queue_req(bpfl_pkg::REQ_ACQUIRE, 6'h15);
        queue_req(bpfl_pkg::REQ_RELEASE, 6'd63);

        write_block_count(2);
        queue_req(bpfl_pkg::REQ_ACQUIRE, 6'd0);
        queue_req(bpfl_pkg::REQ_ACQUIRE, 6'd0);
        queue_req(bpfl_pkg::REQ_ACQUIRE, 6'd0);
        queue_req(bpfl_pkg::REQ_RELEASE, 6'd1);
        queue_req(bpfl_pkg::REQ_RELEASE, 6'd0);
        queue_req(bpfl_pkg::REQ_RELEASE, 6'd2);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_block_count(PHASE_COUNT[p]);
            if (p == NUM_PHASES - 1) begin
                calm <= 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
                while (req_backlog.size() >= 3) begin
                    @(posedge aclk);
                end
                req_backlog.push_back(random_req(PHASE_ACQ[p]));
                // back up the result channel while requests keep coming
                if (p == 0 && n == 30) begin
                    @(posedge aclk);
                    hold_go <= 1'b1;
                    @(posedge aclk);
                    hold_go <= 1'b0;
                end
            end
        end

        drain = 0;
        @(negedge aclk);
        while ((req_backlog.size() != 0 || s_valid || rsp_due.size() != 0)
               && drain < DRAIN_LIMIT) begin
            @(negedge aclk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (rsp_due.size() != 0) begin
            log_mismatch($sformatf("%0d results never returned", rsp_due.size()));
        end

        $display("Ran %0d requests (%0d results checked) over %0d pool size writes",
                 reqs_accepted, rsps_checked, cfg_writes);
        $display("Statuses: ok %0d, disabled %0d, exhausted %0d, corrupt %0d, double %0d, ignored %0d",
                 status_seen[bpfl_pkg::ST_OK], status_seen[bpfl_pkg::ST_DISABLED],
                 status_seen[bpfl_pkg::ST_EXHAUSTED], status_seen[bpfl_pkg::ST_CORRUPT],
                 status_seen[bpfl_pkg::ST_DOUBLE], status_seen[bpfl_pkg::ST_IGNORED]);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/bpfl_pkg.sv
rtl/bpfl_ram.sv
rtl/bpfl_cfg.sv
rtl/block_pool_free_list_unit.sv
verif/tb_block_pool_free_list_unit.sv
